[hw/rtl/oenfs_pkg.sv]
// Package with register indexes, reset values and defaults for the odd elastic force summer.
package oenfs_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_AW-1:0] REG_REST_LENGTH = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ODD_GAIN    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SPRING_GAIN = 3'd2;
    localparam logic [CFG_AW-1:0] REG_BOX_X       = 3'd3;
    localparam logic [CFG_AW-1:0] REG_BOX_Y       = 3'd4;

    localparam logic [30:0] RST_REST_LENGTH = 31'd65536;
    localparam logic [31:0] RST_ODD_GAIN    = 32'd65536;
    localparam logic [31:0] RST_SPRING_GAIN = 32'd32768;
    localparam logic [30:0] RST_BOX_X       = 31'd3932160;
    localparam logic [30:0] RST_BOX_Y       = 31'd1702675;

endpackage

[hw/rtl/odd_elastic_neighbor_force_sum_core.sv]
// Top level of the odd elastic neighbor force summer: sequencer and shared datapath.
//
// Each input transaction carries one particle position, one neighbor position and a
// flag that marks the last neighbor of that particle. The block wraps the separation
// into the periodic box, takes the distance by a digit-by-digit square root, forms the
// unit vector by two restoring divisions and then adds the spring and transverse terms
// into two saturating accumulators. On the last neighbor it issues one output
// transaction with both sums and clears them.
//
// Sequence per pair: the idle step takes the pair, then the wrap, the two squares through
// the single shared 34x34 multiplier, the square root, the two divisions (one quotient
// bit a cycle), the six scaling products and the accumulate step, and back to idle for
// the next pair. A zero distance skips the divisions and the products. The block is
// stalled toward the sender from taking a pair until it is back in idle, so it takes no
// new pair before it is through with the last one.
//
// Reset (synchronous, active low) loads the register defaults and clears both sums and
// the output valid. The result sits in an output register; while the receiver stalls,
// the block still accepts and works on further pairs and only waits at the final
// accumulate step when a new result would overwrite one not yet taken.
module odd_elastic_neighbor_force_sum_core #(
    parameter int FRAC_BITS = oenfs_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [oenfs_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [oenfs_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [31:0]           i_self_x,
    input  logic signed [31:0]           i_self_y,
    input  logic signed [31:0]           i_neigh_x,
    input  logic signed [31:0]           i_neigh_y,
    input  logic                         i_last_neighbor,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [31:0]           o_vel_x,
    output logic signed [31:0]           o_vel_y
);
    import oenfs_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 2);
    localparam int QW = FRAC_BITS + 1;
    localparam int MW = 34;
    localparam int PW = 2 * MW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MIMG, ST_SQ, ST_SQRT, ST_DIVX, ST_DIVY, ST_MUL, ST_ACC
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_cnt;

    logic [30:0] r_rest, r_box_x, r_box_y;
    logic signed [31:0] r_odd, r_spring;

    logic signed [31:0] r_sx, r_sy, r_nbx, r_nby, r_dx, r_dy;
    logic r_last, r_zero;

    logic [63:0] r_v, r_res, r_bit;
    logic [31:0] r_root;
    logic [31:0] r_rem;
    logic [QW-1:0] r_shf, r_q;
    logic signed [QW:0] r_nx, r_ny;

    logic signed [PW-1:0] r_prod;
    logic signed [MW-1:0] r_ex, r_ey;
    logic signed [PW-1:0] r_tx, r_ty;
    logic signed [31:0] r_sum_x, r_sum_y;

    // Minimum image against one box length, then clamped to 32 bits.
    function automatic logic signed [31:0] min_img(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic [30:0] box);
        logic signed [33:0] diff;
        logic signed [33:0] mag;
        logic signed [33:0] d;
        diff = 34'(a) - 34'(b);
        mag  = diff[33] ? -diff : diff;
        if ({mag[32:0], 1'b0} <= {3'b000, box})
            d = diff;
        else if (a < b)
            d = diff + $signed({3'b000, box});
        else
            d = diff - $signed({3'b000, box});
        if (d > 34'sh07FFFFFFF)
            min_img = 32'sh7FFFFFFF;
        else if (d < -34'sh080000000)
            min_img = 32'sh80000000;
        else
            min_img = d[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PW:0] v);
        if (v > (PW+1)'(64'sh7FFFFFFF))
            sat32 = 32'sh7FFFFFFF;
        else if (v < -(PW+1)'(64'sh80000000))
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    // Shared multiplier with its operand selection.
    logic signed [MW-1:0] m_a, m_b;
    logic signed [PW-1:0] w_prod, w_sh;
    logic signed [MW-1:0] w_e;
    logic signed [MW-1:0] w_nx_ext, w_ny_ext;

    assign w_e      = $signed({2'b00, r_root}) - $signed({3'b000, r_rest});
    assign w_nx_ext = MW'(r_nx);
    assign w_ny_ext = MW'(r_ny);
    assign w_prod   = m_a * m_b;
    assign w_sh     = r_prod >>> FRAC_BITS;

    always_comb begin
        m_a = '0;
        m_b = '0;
        if (r_state == ST_SQ) begin
            m_a = (r_cnt == '0) ? MW'(r_dx) : MW'(r_dy);
            m_b = m_a;
        end else if (r_state == ST_MUL) begin
            case (r_cnt)
                CW'(0): begin m_a = w_e;          m_b = w_nx_ext; end
                CW'(1): begin m_a = w_e;          m_b = w_ny_ext; end
                CW'(2): begin m_a = MW'(r_odd);    m_b = r_ex;     end
                CW'(3): begin m_a = MW'(r_spring); m_b = r_ex;     end
                CW'(4): begin m_a = MW'(r_odd);    m_b = r_ey;     end
                CW'(5): begin m_a = MW'(r_spring); m_b = r_ey;     end
                default: begin m_a = '0;          m_b = '0;       end
            endcase
        end
    end

    // Square root step.
    logic [63:0] w_trial, n_v, n_res;
    always_comb begin
        w_trial = r_res + r_bit;
        if (r_v >= w_trial) begin
            n_v   = r_v - w_trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_v   = r_v;
            n_res = r_res >> 1;
        end
    end

    // Restoring division step, one quotient bit.
    logic [32:0] w_t;
    logic        w_qbit;
    logic [31:0] n_rem;
    logic [QW-1:0] n_q;
    always_comb begin
        w_t    = {r_rem, r_shf[QW-1]};
        w_qbit = (w_t >= {1'b0, r_root});
        n_rem  = w_qbit ? 32'(w_t - {1'b0, r_root}) : w_t[31:0];
        n_q    = {r_q[QW-2:0], w_qbit};
    end

    logic [31:0] w_adx, w_ady;
    assign w_adx = r_dx[31] ? 32'(-r_dx) : 32'(r_dx);
    assign w_ady = r_dy[31] ? 32'(-r_dy) : 32'(r_dy);

    logic signed [PW:0] w_acc_x, w_acc_y;
    assign w_acc_x = (PW+1)'(r_sum_x) + (PW+1)'(r_tx);
    assign w_acc_y = (PW+1)'(r_sum_y) + (PW+1)'(r_ty);

    logic signed [31:0] n_sum_x, n_sum_y;
    assign n_sum_x = r_zero ? r_sum_x : sat32(w_acc_x);
    assign n_sum_y = r_zero ? r_sum_y : sat32(w_acc_y);

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_rest      <= RST_REST_LENGTH;
            r_odd       <= RST_ODD_GAIN;
            r_spring    <= RST_SPRING_GAIN;
            r_box_x     <= RST_BOX_X;
            r_box_y     <= RST_BOX_Y;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_REST_LENGTH: r_rest   <= i_cfg_wdata[30:0];
                    REG_ODD_GAIN:    r_odd    <= i_cfg_wdata;
                    REG_SPRING_GAIN: r_spring <= i_cfg_wdata;
                    REG_BOX_X:       r_box_x  <= i_cfg_wdata[30:0];
                    REG_BOX_Y:       r_box_y  <= i_cfg_wdata[30:0];
                    default: ;
                endcase
            end

            // A new result is raised in the accumulate step; otherwise a taken one drops.
            if (r_state == ST_ACC && r_last && !(o_out_valid && i_out_stall))
                o_out_valid <= 1'b1;
            else if (o_out_valid && !i_out_stall)
                o_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_sx    <= i_self_x;
                        r_sy    <= i_self_y;
                        r_nbx   <= i_neigh_x;
                        r_nby   <= i_neigh_y;
                        r_last  <= i_last_neighbor;
                        r_state <= ST_MIMG;
                    end
                end
                ST_MIMG: begin
                    r_dx    <= min_img(r_sx, r_nbx, r_box_x);
                    r_dy    <= min_img(r_sy, r_nby, r_box_y);
                    r_cnt   <= '0;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(1))
                        r_v <= r_prod[63:0];
                    if (r_cnt == CW'(2)) begin
                        r_v     <= r_v + r_prod[63:0];
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_v   <= n_v;
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_root <= n_res[31:0];
                        r_rem  <= {1'b0, w_adx[31:1]};
                        r_shf  <= {w_adx[0], {FRAC_BITS{1'b0}}};
                        r_q    <= '0;
                        r_cnt  <= '0;
                        r_zero <= (n_res == '0);
                        r_state <= (n_res == '0) ? ST_ACC : ST_DIVX;
                    end
                end
                ST_DIVX: begin
                    if (r_cnt == CW'(FRAC_BITS)) begin
                        r_nx    <= r_dx[31] ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
                        r_rem   <= {1'b0, w_ady[31:1]};
                        r_shf   <= {w_ady[0], {FRAC_BITS{1'b0}}};
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIVY;
                    end else begin
                        r_rem <= n_rem;
                        r_shf <= r_shf << 1;
                        r_q   <= n_q;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_DIVY: begin
                    if (r_cnt == CW'(FRAC_BITS)) begin
                        r_ny    <= r_dy[31] ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
                        r_cnt   <= '0;
                        r_state <= ST_MUL;
                    end else begin
                        r_rem <= n_rem;
                        r_shf <= r_shf << 1;
                        r_q   <= n_q;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_MUL: begin
                    // Each step consumes the product registered in the step before.
                    r_cnt <= r_cnt + CW'(1);
                    case (r_cnt)
                        CW'(1): r_ex <= w_sh[MW-1:0];
                        CW'(2): r_ey <= w_sh[MW-1:0];
                        CW'(3): r_ty <= w_sh;
                        CW'(4): r_tx <= -w_sh;
                        CW'(5): r_tx <= r_tx - w_sh;
                        CW'(6): begin
                            r_ty    <= r_ty - w_sh;
                            r_state <= ST_ACC;
                        end
                        default: ;
                    endcase
                end
                ST_ACC: begin
                    if (!(r_last && o_out_valid && i_out_stall)) begin
                        if (r_last) begin
                            o_vel_x     <= n_sum_x;
                            o_vel_y     <= n_sum_y;
                            r_sum_x     <= '0;
                            r_sum_y     <= '0;
                        end else begin
                            r_sum_x <= n_sum_x;
                            r_sum_y <= n_sum_y;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> (r_state == ST_IDLE))
        else $error("input accepted while busy");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVX || r_state == ST_DIVY) |-> (r_root != '0))
        else $error("division entered with zero distance");

    a_out_from_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_ACC && $past(r_last)))
        else $error("result issued outside a last-neighbor accumulate");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_vel_x)))
        else $error("pending result overwritten");

endmodule

[test/odd_elastic_neighbor_force_sum_core_checker.sv]
// Checker for the odd elastic neighbor force summer: predicts and compares the summed velocities.
module odd_elastic_neighbor_force_sum_core_checker
    import oenfs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [CFG_DW-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic signed [31:0]   i_self_x,
    input  logic signed [31:0]   i_self_y,
    input  logic signed [31:0]   i_neigh_x,
    input  logic signed [31:0]   i_neigh_y,
    input  logic                 i_last_neighbor,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic signed [31:0]   i_vel_x,
    input  logic signed [31:0]   i_vel_y,
    output int                   o_failures,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } t_velocity;

    t_velocity velocity_q[$];

    longint rest_len, k_odd, k_spring, len_x, len_y;
    longint acc_x, acc_y;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint wrap_sep(longint a, longint b, longint len);
        longint diff, mag;
        diff = a - b;
        mag = (diff < 0) ? -diff : diff;
        if (2 * mag <= len) return clamp32(diff);
        if (a < b) return clamp32(diff + len);
        return clamp32(diff - len);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Adds one pair's force into the sums; arithmetic shift gives the floor division.
    task automatic add_pair_force(longint sx, longint sy, longint nxp, longint nyp);
        longint dx, dy, r, ux, uy, e, ex, ey;
        longint unsigned sq;
        dx = wrap_sep(sx, nxp, len_x);
        dy = wrap_sep(sy, nyp, len_y);
        sq = longint'(dx * dx) + longint'(dy * dy);
        r = longint'(root_floor(sq));
        if (r != 0) begin
            ux = (dx <<< FB) / r;
            uy = (dy <<< FB) / r;
            e = r - rest_len;
            ex = (e * ux) >>> FB;
            ey = (e * uy) >>> FB;
            acc_x = clamp32(acc_x - ((k_odd * ey) >>> FB) - ((k_spring * ex) >>> FB));
            acc_y = clamp32(acc_y + ((k_odd * ex) >>> FB) - ((k_spring * ey) >>> FB));
        end
    endtask

    assign o_pending = velocity_q.size();

    always @(posedge i_clk) begin
        t_velocity want;
        if (!i_rst_n) begin
            rest_len = longint'(RST_REST_LENGTH);
            k_odd = longint'(signed'(RST_ODD_GAIN));
            k_spring = longint'(signed'(RST_SPRING_GAIN));
            len_x = longint'(RST_BOX_X);
            len_y = longint'(RST_BOX_Y);
            acc_x = 0;
            acc_y = 0;
            o_failures = 0;
            velocity_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_REST_LENGTH: rest_len = longint'(i_cfg_wdata[30:0]);
                    REG_ODD_GAIN:    k_odd = longint'(signed'(i_cfg_wdata));
                    REG_SPRING_GAIN: k_spring = longint'(signed'(i_cfg_wdata));
                    REG_BOX_X:       len_x = longint'(i_cfg_wdata[30:0]);
                    REG_BOX_Y:       len_y = longint'(i_cfg_wdata[30:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                add_pair_force(i_self_x, i_self_y, i_neigh_x, i_neigh_y);
                if (i_last_neighbor) begin
                    velocity_q.push_back('{vx: acc_x[31:0], vy: acc_y[31:0]});
                    acc_x = 0;
                    acc_y = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (velocity_q.size() == 0) begin
                    $display("%0t: unexpected result vel_x=%0d vel_y=%0d",
                             $time, i_vel_x, i_vel_y);
                    o_failures++;
                end else begin
                    want = velocity_q.pop_front();
                    if (want.vx !== i_vel_x) begin
                        $display("%0t: vel_x expected %0d actual %0d", $time, want.vx, i_vel_x);
                        o_failures++;
                    end
                    if (want.vy !== i_vel_y) begin
                        $display("%0t: vel_y expected %0d actual %0d", $time, want.vy, i_vel_y);
                        o_failures++;
                    end
                end
            end
        end
    end

endmodule

[test/odd_elastic_neighbor_force_sum_core_test.sv]
// Top of the force summer testbench: clock, reset, stimulus, watchdog and verdict.
module odd_elastic_neighbor_force_sum_core_test;
    import oenfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // No transaction in the block lasts this many quiet cycles, so reaching the limit means a hang.
    localparam int QUIET_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 150;
    localparam int PAIRS_PER_PHASE = 215;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr = '0;
    logic [CFG_DW-1:0]    i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic signed [31:0]   i_self_x = '0;
    logic signed [31:0]   i_self_y = '0;
    logic signed [31:0]   i_neigh_x = '0;
    logic signed [31:0]   i_neigh_y = '0;
    logic                 i_last_neighbor = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [31:0]   o_vel_x;
    logic signed [31:0]   o_vel_y;

    int failures;
    int pending;
    int quiet_cycles = 0;
    // While set, neither the sender nor the receiver idles.
    bit steady = 1'b0;

    always #5 i_clk = ~i_clk;

    odd_elastic_neighbor_force_sum_core dut (.*);

    odd_elastic_neighbor_force_sum_core_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_in_valid, .i_in_stall(o_in_stall),
        .i_self_x, .i_self_y, .i_neigh_x, .i_neigh_y, .i_last_neighbor,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_vel_x(o_vel_x), .i_vel_y(o_vel_y),
        .o_failures(failures), .o_pending(pending)
    );

    // The receiver stalls in about one cycle of six unless the steady stretch is on.
    always @(posedge i_clk) begin
        i_out_stall <= steady ? 1'b0 : ($urandom_range(99) < 16);
    end

    // The watchdog restarts whenever either channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("odd_elastic_neighbor_force_sum_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The sender goes quiet first, then register writes wait until the block has
    // drained, with margin for a pair that is still in flight toward a result.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The write enable stays high across back-to-back writes; the caller lowers it.
    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic load_regs(logic [31:0] rest, logic [31:0] k_odd, logic [31:0] k_spring,
                             logic [31:0] bx, logic [31:0] by);
        settle_block();
        write_reg(REG_REST_LENGTH, rest);
        write_reg(REG_ODD_GAIN, k_odd);
        write_reg(REG_SPRING_GAIN, k_spring);
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drives one pair transaction at the current edge and returns at the edge that takes
    // it. The stall is read at the falling edge, where it is stable.
    task automatic send_pair(logic [31:0] sx, logic [31:0] sy, logic [31:0] nx,
                             logic [31:0] ny, logic last);
        bit taken;
        i_self_x <= sx;
        i_self_y <= sy;
        i_neigh_x <= nx;
        i_neigh_y <= ny;
        i_last_neighbor <= last;
        i_in_valid <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        // The valid drops only when the sender pauses, so it is never lowered and raised
        // in the same step.
        if (!steady && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Positions are mostly within a few box lengths, with full-range and extreme values
    // mixed in so that every bit toggles and the separations saturate.
    function automatic logic [31:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65) return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
        if (sel < 85) return $urandom;
        if (sel < 92) return 32'h7FFF_FFFF;
        if (sel < 99) return 32'h8000_0000;
        return 32'h0;
    endfunction

    task automatic random_pairs(int count);
        logic [31:0] sx, sy, nx, ny;
        for (int k = 0; k < count; k++) begin
            sx = pick_coord();
            sy = pick_coord();
            nx = pick_coord();
            ny = pick_coord();
            // Some pairs sit on the same point or only a hair apart.
            if ($urandom_range(99) < 8) begin
                nx = sx;
                ny = sy;
            end else if ($urandom_range(99) < 8) begin
                nx = sx + $urandom_range(0, 3);
                ny = sy;
            end
            // Every phase closes with a last neighbor so that the block ends up idle.
            send_pair(sx, sy, nx, ny, (k == count - 1) || ($urandom_range(99) < 22));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs at the reset register values.
        send_pair(32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1);           // one unit apart
        send_pair(32'h0002_0000, 32'h0003_0000, 32'h0002_0000, 32'h0003_0000, 1'b1); // zero
        send_pair(32'h0, 32'h0, 32'h0, 32'h0002_0000, 1'b0);           // pure y offset
        send_pair(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 1'b1);   // two summed
        send_pair(32'h0, 32'h0, 32'h0038_0000, 32'h0, 1'b1);           // wraps in x
        send_pair(32'h0038_0000, 32'h0, 32'h0, 32'h0018_0000, 1'b1);   // wraps both ways
        send_pair(32'h001E_0000, 32'h0, 32'h0, 32'h0, 1'b1);           // exactly half a box
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_pair(32'h0, 32'h0, 32'h0, 32'h1, 1'b1);                   // tiny distance
        send_pair(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 1'b0);
        send_pair(32'h1234_5678, 32'hEDCB_A987, 32'h0, 32'h0, 1'b1);
        random_pairs(PAIRS_PER_PHASE);

        // Extremes: no rest length, largest gains of opposite sign, one box off.
        load_regs(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 1'b0);   // drives the sums
        send_pair(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 1'b0);   // into saturation
        send_pair(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b1);
        random_pairs(PAIRS_PER_PHASE);

        // The opposite extremes, with the y box switched off instead.
        load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        send_pair(32'h0, 32'h0, 32'h0000_8000, 32'h0, 1'b1);
        random_pairs(PAIRS_PER_PHASE);

        // Moderate random settings, the first half without any idling on either side.
        load_regs($urandom_range(0, 32'h0004_0000),
                  32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
                  32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
                  $urandom_range(32'h000A_0000, 32'h0050_0000),
                  $urandom_range(32'h000A_0000, 32'h0050_0000));
        steady = 1'b1;
        random_pairs(PAIRS_PER_PHASE / 2);
        steady = 1'b0;
        random_pairs(PAIRS_PER_PHASE / 2);

        // Back to the reset values.
        load_regs(32'(RST_REST_LENGTH), RST_ODD_GAIN, RST_SPRING_GAIN,
                  32'(RST_BOX_X), 32'(RST_BOX_Y));
        random_pairs(PAIRS_PER_PHASE);

        settle_block();
        if (failures == 0) begin
            $display("odd_elastic_neighbor_force_sum_core test passed");
        end else begin
            $display("odd_elastic_neighbor_force_sum_core test failed");
        end
        $finish;
    end

endmodule
